FILE: design/stc_pkg.sv
// Shared types and constants for the safety timestamp and time correction block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package stc_pkg;

  // Free-running time width and the fixed width of the now_us field.
  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned NOW_W         = 48;

  // A message later than this after the last produced frame is dropped.
  localparam int unsigned LATE_LIMIT_US = 2000;
  // One tick is 128 us; the slew step is one eighth of the remaining distance.
  localparam int unsigned TICK_SHIFT    = 7;
  localparam int unsigned SLEW_SHIFT    = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic FUNC_PRODUCE = 1'b0;
  localparam logic FUNC_COORD   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_TS    = 3'd0,
    CFG_INIT_RO    = 3'd1,
    CFG_CORR_CONST = 3'd2,
    CFG_RPI        = 3'd3,
    CFG_PING_IVL   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OUT_IDLE  = 3'd0,
    OUT_RUN   = 3'd1,
    OUT_USED  = 3'd2,
    OUT_LATE  = 3'd3,
    OUT_FIRST = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [15:0] init_ts;
    logic [15:0] init_ro;
    logic [15:0] corr_const;
    logic [23:0] rpi_us;
    logic [31:0] ping_ivl_us;
  } cfg_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [15:0] timestamp;
    logic [15:0] rollover_count;
    logic [1:0]  ping_count;
    logic        run_flag;
    logic [15:0] correction_applied;
  } result_t;

endpackage

FILE: design/stc_cfg.sv
// Configuration register file of the safety timestamp block.
// Depends on stc_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module stc_cfg import stc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INIT_TS:    cfg_q.init_ts     <= cfg_wdata_i[15:0];
        CFG_INIT_RO:    cfg_q.init_ro     <= cfg_wdata_i[15:0];
        CFG_CORR_CONST: cfg_q.corr_const  <= cfg_wdata_i[15:0];
        CFG_RPI:        cfg_q.rpi_us      <= cfg_wdata_i[23:0];
        CFG_PING_IVL:   cfg_q.ping_ivl_us <= cfg_wdata_i;
        default: begin
          // Writes to unknown indexes are ignored.
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/stc_core.sv
// Timestamp state and the single-pass step logic for produce and coordination words.
// Depends on stc_pkg for cfg_t, result_t, the outcome codes and the timing constants.
`timescale 1ns / 1ps

module stc_core import stc_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  cfg_t             cfg_i,
  input  logic             func_i,
  input  logic [NOW_W-1:0] now_us_i,
  input  logic [15:0]      ctv_i,
  output result_t          res_o
);

  logic                 active_q, active_d;
  logic                 seen_q, seen_d;
  logic                 frame_vld_q, frame_vld_d;
  logic                 sent_vld_q, sent_vld_d;
  logic                 ping_vld_q, ping_vld_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] last_frame_q, last_frame_d;
  logic [TIME_BITS-1:0] last_sent_q, last_sent_d;
  logic [TIME_BITS-1:0] last_ping_q, last_ping_d;
  logic [15:0]          lps_q, lps_d;
  logic [15:0]          corr_val_q, corr_val_d;
  logic [15:0]          corr_goal_q, corr_goal_d;
  logic [15:0]          rollover_q, rollover_d;
  logic [1:0]           ping_q, ping_d;

  logic [63:0]          now_ext, ivl_ext;
  logic [TIME_BITS-1:0] now_t, ivl_t;
  logic [TIME_BITS-1:0] elapsed, raw, corr_sum, corr_fin, ping_ref, ping_diff, frame_diff;
  logic [15:0]          slew_diff, slew_step, slew_val;
  logic signed [15:0]   slew_sd;
  logic [15:0]          worst, delta, goal_diff;
  logic signed [15:0]   delta_s, goal_diff_s;
  logic [16:0]          thresh;
  logic                 late;
  result_t              res;

  assign now_ext = {{(64 - NOW_W){1'b0}}, now_us_i};
  assign ivl_ext = {32'd0, cfg_i.ping_ivl_us};
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign ivl_t   = ivl_ext[TIME_BITS-1:0];

  // Produce path: ticks since start, slewed correction and the forward-only guard.
  assign elapsed   = now_t - start_q;
  assign raw       = TIME_BITS'(cfg_i.init_ts) + (elapsed >> TICK_SHIFT);
  assign slew_diff = corr_goal_q - corr_val_q;
  assign slew_sd   = slew_diff;

  always_comb begin
    slew_step = slew_diff >> SLEW_SHIFT;
    if (slew_step == 16'd0) begin
      slew_step = 16'd1;
    end
    if (corr_val_q == corr_goal_q) begin
      slew_val = corr_val_q;
    end else if (slew_sd > 16'sd0) begin
      slew_val = corr_val_q + slew_step;
    end else begin
      slew_val = corr_goal_q;
    end
  end

  assign corr_sum = raw + TIME_BITS'(slew_val);
  assign corr_fin = (sent_vld_q && (corr_sum < last_sent_q)) ? last_sent_q + TIME_BITS'(1)
                    : corr_sum;

  // The first active frame starts the ping reference, so its distance is zero.
  assign ping_ref  = ping_vld_q ? last_ping_q : now_t;
  assign ping_diff = now_t - ping_ref;

  // Coordination path.
  assign frame_diff  = now_t - last_frame_q;
  assign late        = frame_vld_q && (frame_diff > TIME_BITS'(LATE_LIMIT_US));
  assign worst       = ctv_i - lps_q - cfg_i.corr_const;
  assign delta       = worst - corr_val_q;
  assign delta_s     = delta;
  assign goal_diff   = worst - corr_goal_q;
  assign goal_diff_s = goal_diff;
  assign thresh      = ((cfg_i.rpi_us >> TICK_SHIFT) == 24'd0) ? 17'd1
                       : cfg_i.rpi_us[TICK_SHIFT +: 17];

  always_comb begin
    active_d     = active_q;
    seen_d       = seen_q;
    frame_vld_d  = frame_vld_q;
    sent_vld_d   = sent_vld_q;
    ping_vld_d   = ping_vld_q;
    start_d      = start_q;
    last_frame_d = last_frame_q;
    last_sent_d  = last_sent_q;
    last_ping_d  = last_ping_q;
    lps_d        = lps_q;
    corr_val_d   = corr_val_q;
    corr_goal_d  = corr_goal_q;
    rollover_d   = rollover_q;
    ping_d       = ping_q;
    res.outcome   = OUT_IDLE;
    res.timestamp = 16'd0;
    res.run_flag  = 1'b0;

    if (func_i == FUNC_PRODUCE) begin
      if (active_q) begin
        res.outcome   = OUT_RUN;
        res.run_flag  = 1'b1;
        res.timestamp = corr_fin[15:0];
        last_frame_d  = now_t;
        frame_vld_d   = 1'b1;
        lps_d         = raw[15:0];
        corr_val_d    = slew_val;
        last_sent_d   = corr_fin;
        sent_vld_d    = 1'b1;
        rollover_d    = cfg_i.init_ro + corr_fin[31:16];
        ping_vld_d    = 1'b1;
        last_ping_d   = ping_ref;
        if ((cfg_i.ping_ivl_us != 32'd0) && (ping_diff >= ivl_t)) begin
          last_ping_d = now_t;
          ping_d      = ping_q + 2'd1;
        end
      end
    end else begin
      res.run_flag = 1'b1;
      if (!active_q) begin
        active_d   = 1'b1;
        rollover_d = cfg_i.init_ro;
        start_d    = now_t;
      end
      if (late) begin
        res.outcome = OUT_LATE;
      end else if (!seen_q) begin
        seen_d      = 1'b1;
        res.outcome = OUT_FIRST;
      end else begin
        res.outcome = OUT_USED;
        // The correction never moves backwards; small steps apply at once.
        if (delta_s > 16'sd0) begin
          if ((corr_val_q == 16'd0) || ({1'b0, delta} <= thresh)) begin
            corr_val_d  = worst;
            corr_goal_d = worst;
          end else if (goal_diff_s > 16'sd0) begin
            corr_goal_d = worst;
          end
        end
      end
    end

    res.rollover_count     = rollover_d;
    res.ping_count         = ping_d;
    res.correction_applied = corr_val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      seen_q       <= 1'b0;
      frame_vld_q  <= 1'b0;
      sent_vld_q   <= 1'b0;
      ping_vld_q   <= 1'b0;
      start_q      <= '0;
      last_frame_q <= '0;
      last_sent_q  <= '0;
      last_ping_q  <= '0;
      lps_q        <= '0;
      corr_val_q   <= '0;
      corr_goal_q  <= '0;
      rollover_q   <= '0;
      ping_q       <= '0;
    end else if (step_i) begin
      active_q     <= active_d;
      seen_q       <= seen_d;
      frame_vld_q  <= frame_vld_d;
      sent_vld_q   <= sent_vld_d;
      ping_vld_q   <= ping_vld_d;
      start_q      <= start_d;
      last_frame_q <= last_frame_d;
      last_sent_q  <= last_sent_d;
      last_ping_q  <= last_ping_d;
      lps_q        <= lps_d;
      corr_val_q   <= corr_val_d;
      corr_goal_q  <= corr_goal_d;
      rollover_q   <= rollover_d;
      ping_q       <= ping_d;
    end
  end

  assign res_o = res;

endmodule

FILE: design/safety_timestamp_time_correction.sv
// Top level of the safety timestamp and consumer time correction block.
// Depends on stc_pkg, stc_cfg and stc_core.
//
// Usage:
//   Input words arrive on in_valid_i/in_ready_o: func_i selects a produce request
//   or a received time-coordination message, now_us_i carries the current time
//   and consumer_time_value_i the consumer time of a message. Each word gives
//   exactly one result word on out_valid_o/out_ready_i.
//   An accepted word sits in the input register, where the step logic reads it
//   with the block state; when it advances, the state updates, the result is
//   registered and out_valid_o rises. While the receiver takes each result, the
//   block takes one word per cycle, set by the single pass through the step logic
//   between the input and result registers. When the receiver stalls, the result
//   holds, the input register keeps one more word, and in_ready_o drops until the
//   result is taken. Configuration is written by the user through
//   cfg_we_i/cfg_index_i/cfg_wdata_i only while no word is in flight; the block
//   does not enforce it. Writes take effect at the next edge. Reset clears the
//   configuration, all timing state and both registers.
`timescale 1ns / 1ps

module safety_timestamp_time_correction import stc_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [NOW_W-1:0]      now_us_i,
  input  logic [15:0]           consumer_time_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            outcome_o,
  output logic [15:0]           timestamp_o,
  output logic [15:0]           rollover_count_o,
  output logic [1:0]            ping_count_o,
  output logic                  run_flag_o,
  output logic [15:0]           correction_applied_o
);

  cfg_t             cfg;
  logic             in_vld_q;
  logic             func_q;
  logic [NOW_W-1:0] now_q;
  logic [15:0]      ctv_q;
  logic             out_vld_q;
  result_t          res, res_q;
  logic             advance;

  stc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held word moves on whenever the result register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      now_q  <= now_us_i;
      ctv_q  <= consumer_time_value_i;
    end
  end

  stc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cfg_i    (cfg),
    .func_i   (func_q),
    .now_us_i (now_q),
    .ctv_i    (ctv_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign outcome_o            = res_q.outcome;
  assign timestamp_o          = res_q.timestamp;
  assign rollover_count_o     = res_q.rollover_count;
  assign ping_count_o         = res_q.ping_count;
  assign run_flag_o           = res_q.run_flag;
  assign correction_applied_o = res_q.correction_applied;

endmodule

FILE: design/stc_checker.sv
// Port-level checks for the safety timestamp block, bound to its top level.
// Depends on stc_pkg for the outcome codes.
`timescale 1ns / 1ps

module stc_checker import stc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  outcome_o,
  input logic [15:0] timestamp_o,
  input logic        run_flag_o,
  input logic [15:0] correction_applied_o
);

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(timestamp_o)
      && $stable(outcome_o) && $stable(correction_applied_o))
    else $error("result word changed while stalled");

  // Only a run frame carries a nonzero timestamp.
  a_stamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_RUN) |-> timestamp_o == 16'd0)
    else $error("timestamp set on a result that is not a run frame");

  // The run flag is low exactly for an idle frame.
  a_run_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_flag_o == (outcome_o != OUT_IDLE)))
    else $error("run flag disagrees with the outcome");

  // With the result register empty, a new result follows a word that was accepted
  // into the input register before it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without an accepted input word");

endmodule

bind safety_timestamp_time_correction stc_checker u_stc_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for safety_timestamp_time_correction: a directed table, then random produce
// requests and time-coordination messages, each result checked against its typed row
// or an in-bench model. Depends on stc_pkg and the block's RTL only.

module tb;
  import stc_pkg::*;

  localparam logic [47:0] T0 = 48'hFFFF_FFFF_F000;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic        fn;
    logic [47:0] now;
    logic [15:0] ctv;
    logic        typed;
    result_t     want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic func_i = 1'b0;
  logic [NOW_W-1:0] now_us_i = '0;
  logic [15:0] consumer_time_value_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, run_flag_o;
  logic [2:0] outcome_o;
  logic [15:0] timestamp_o, rollover_count_o, correction_applied_o;
  logic [1:0] ping_count_o;

  // Timekeeper model state and its configuration copy.
  cfg_t        live_cfg;
  logic        consumer_on, corr_seen, frame_seen, ticks_seen, ping_ref_seen;
  logic [47:0] prod_start_us, last_frame_us, last_ticks, ping_ref_us;
  logic [15:0] last_stamp, applied_corr, goal_corr, rollover;
  logic [1:0]  ping_cnt;

  result_t     expected_frames[$];
  dir_row_t    dir_rows[$];
  logic [47:0] time_cursor;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_off_req = 1'b0;

  safety_timestamp_time_correction DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .func_i               (func_i),
    .now_us_i             (now_us_i),
    .consumer_time_value_i(consumer_time_value_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .outcome_o            (outcome_o),
    .timestamp_o          (timestamp_o),
    .rollover_count_o     (rollover_count_o),
    .ping_count_o         (ping_count_o),
    .run_flag_o           (run_flag_o),
    .correction_applied_o (correction_applied_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t typed_result(outcome_e oc, logic [15:0] ts, logic [15:0] ro,
                                           logic [1:0] pc, logic run, logic [15:0] corr);
    result_t r;
    r.outcome            = oc;
    r.timestamp          = ts;
    r.rollover_count     = ro;
    r.ping_count         = pc;
    r.run_flag           = run;
    r.correction_applied = corr;
    return r;
  endfunction

  // Advances the model by one word and returns the result word it should produce.
  function automatic result_t step_timekeeper(logic fn, logic [47:0] now, logic [15:0] ctv);
    result_t            r;
    logic [47:0]        elapsed, raw, corr_ticks, ping_gap, frame_gap;
    logic [15:0]        worst;
    logic signed [15:0] gap, lead;
    int                 slew, thresh;
    r = '0;
    if (fn == FUNC_PRODUCE) begin
      r.outcome = consumer_on ? OUT_RUN : OUT_IDLE;
      r.run_flag = consumer_on;
      if (consumer_on) begin
        elapsed = now - prod_start_us;
        raw = elapsed >> TICK_SHIFT;
        raw = raw + 48'(live_cfg.init_ts);
        last_frame_us = now;
        frame_seen = 1'b1;
        last_stamp = raw[15:0];
        if (applied_corr != goal_corr) begin
          gap = goal_corr - applied_corr;
          if (gap > 0) begin
            slew = int'(gap) >> SLEW_SHIFT;
            if (slew < 1) slew = 1;
            applied_corr = applied_corr + 16'(slew);
          end else begin
            // A goal that sits behind the applied value is taken as is.
            applied_corr = goal_corr;
          end
        end
        corr_ticks = raw + 48'(applied_corr);
        if (ticks_seen && corr_ticks < last_ticks) corr_ticks = last_ticks + 48'd1;
        r.timestamp = corr_ticks[15:0];
        last_ticks = corr_ticks;
        ticks_seen = 1'b1;
        rollover = live_cfg.init_ro + corr_ticks[31:16];
        if (!ping_ref_seen) begin
          ping_ref_us = now;
          ping_ref_seen = 1'b1;
        end
        ping_gap = now - ping_ref_us;
        if (live_cfg.ping_ivl_us != 0 && ping_gap >= 48'(live_cfg.ping_ivl_us)) begin
          ping_ref_us = now;
          ping_cnt = ping_cnt + 2'd1;
        end
      end
    end else begin
      if (!consumer_on) begin
        consumer_on = 1'b1;
        rollover = live_cfg.init_ro;
        prod_start_us = now;
      end
      r.run_flag = 1'b1;
      frame_gap = now - last_frame_us;
      if (frame_seen && frame_gap > 48'(LATE_LIMIT_US)) begin
        r.outcome = OUT_LATE;
      end else begin
        worst = ctv - last_stamp - live_cfg.corr_const;
        gap = worst - applied_corr;
        if (!corr_seen) begin
          corr_seen = 1'b1;
          r.outcome = OUT_FIRST;
        end else begin
          thresh = int'(live_cfg.rpi_us >> TICK_SHIFT);
          if (thresh < 1) thresh = 1;
          // The correction only ever moves forward.
          if (gap > 0) begin
            if (applied_corr == 0 || int'(gap) <= thresh) begin
              applied_corr = worst;
              goal_corr = worst;
            end else begin
              lead = worst - goal_corr;
              if (lead > 0) goal_corr = worst;
            end
          end
          r.outcome = OUT_USED;
        end
      end
    end
    r.rollover_count = rollover;
    r.ping_count = ping_cnt;
    r.correction_applied = applied_corr;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken,
  // with valid still high so that the next word can follow without a gap.
  task automatic send_word(logic fn, logic [47:0] now, logic [15:0] ctv, logic typed,
                           result_t want);
    result_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = fn;
    now_us_i = now;
    consumer_time_value_i = ctv;
    do @(posedge clk_i); while (!in_ready_o);
    pred = step_timekeeper(fn, now, ctv);
    expected_frames.insert(expected_frames.size(), typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_INIT_TS:    live_cfg.init_ts = val[15:0];
      CFG_INIT_RO:    live_cfg.init_ro = val[15:0];
      CFG_CORR_CONST: live_cfg.corr_const = val[15:0];
      CFG_RPI:        live_cfg.rpi_us = val[23:0];
      CFG_PING_IVL:   live_cfg.ping_ivl_us = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_settings(logic [15:0] ts, logic [15:0] ro, logic [15:0] cc,
                                logic [23:0] rpi, logic [31:0] ping);
    write_reg(CFG_INIT_TS, 32'(ts));
    write_reg(CFG_INIT_RO, 32'(ro));
    write_reg(CFG_CORR_CONST, 32'(cc));
    write_reg(CFG_RPI, 32'(rpi));
    write_reg(CFG_PING_IVL, ping);
  endtask

  task automatic random_word();
    logic        fn;
    logic [47:0] now;
    logic [15:0] ctv;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      fn = 1'($urandom_range(1));
      now = {16'($urandom), $urandom};
      ctv = 16'($urandom);
    end else begin
      pick = $urandom_range(99);
      if (pick < 3) time_cursor = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(20000));
      else if (pick < 7) time_cursor = time_cursor - 48'($urandom_range(1500, 1));
      else if (pick < 15) time_cursor = time_cursor + 48'($urandom_range(6000, 2001));
      else time_cursor = time_cursor + 48'($urandom_range(1400, 20));
      now = time_cursor;
      fn = ($urandom_range(99) < 35) ? FUNC_COORD : FUNC_PRODUCE;
      // Aim the consumer time near what the block holds, so corrections fall on
      // both sides of the instant threshold.
      ctv = last_stamp + live_cfg.corr_const + applied_corr;
      pick = $urandom_range(99);
      if (pick < 50) ctv = ctv + 16'($urandom_range(16)) - 16'd8;
      else if (pick < 80) ctv = ctv + 16'($urandom_range(400, 9));
      else ctv = 16'($urandom);
    end
    send_word(fn, now, ctv, 1'b0, '0);
  endtask

  task automatic run_phase(int count);
    repeat (count) random_word();
  endtask

  task automatic add_row(logic fn, logic [47:0] now, logic [15:0] ctv, logic typed,
                         result_t want);
    dir_row_t row;
    row.fn = fn;
    row.now = now;
    row.ctv = ctv;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t got, want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (out_valid_o && out_ready_i) begin
      got.outcome            = outcome_e'(outcome_o);
      got.timestamp          = timestamp_o;
      got.rollover_count     = rollover_count_o;
      got.ping_count         = ping_count_o;
      got.run_flag           = run_flag_o;
      got.correction_applied = correction_applied_o;
      if (expected_frames.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("%0t: result word with nothing expected: outcome %0d ts %h", $time,
                   got.outcome, got.timestamp);
      end else begin
        want = expected_frames.pop_front();
        if (got.outcome !== want.outcome || got.timestamp !== want.timestamp ||
            got.rollover_count !== want.rollover_count ||
            got.ping_count !== want.ping_count || got.run_flag !== want.run_flag ||
            got.correction_applied !== want.correction_applied) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("%0t: mismatch (outcome ts rollover ping run corr)", $time);
            $display("  expected %0d %h %h %0d %0d %h", want.outcome, want.timestamp,
                     want.rollover_count, want.ping_count, want.run_flag,
                     want.correction_applied);
            $display("  actual   %0d %h %h %0d %0d %h", got.outcome, got.timestamp,
                     got.rollover_count, got.ping_count, got.run_flag,
                     got.correction_applied);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    live_cfg = '0;
    consumer_on = 1'b0;
    corr_seen = 1'b0;
    frame_seen = 1'b0;
    ticks_seen = 1'b0;
    ping_ref_seen = 1'b0;
    prod_start_us = '0;
    last_frame_us = '0;
    last_ticks = '0;
    ping_ref_us = '0;
    last_stamp = '0;
    applied_corr = '0;
    goal_corr = '0;
    rollover = '0;
    ping_cnt = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 73;
    write_settings(16'h0000, 16'hFFFF, 16'h0000, 24'h000000, 32'd1000);

    // Frames before any message are idle; the first message starts production
    // near the top of the time range, so later rows cross the wrap.
    add_row(FUNC_PRODUCE, 48'd0, 16'h0000, 1'b1,
            typed_result(OUT_IDLE, 16'h0, 16'h0, 2'd0, 1'b0, 16'h0));
    add_row(FUNC_PRODUCE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
            typed_result(OUT_IDLE, 16'h0, 16'h0, 2'd0, 1'b0, 16'h0));
    add_row(FUNC_COORD, T0, 16'hFFFF, 1'b1,
            typed_result(OUT_FIRST, 16'h0, 16'hFFFF, 2'd0, 1'b1, 16'h0));
    add_row(FUNC_PRODUCE, T0 + 48'h280, 16'h0, 1'b1,
            typed_result(OUT_RUN, 16'd5, 16'hFFFF, 2'd0, 1'b1, 16'h0));
    add_row(FUNC_COORD, T0 + 48'h300, 16'h0010, 1'b0, '0);
    add_row(FUNC_PRODUCE, T0 + 48'h600, 16'h0, 1'b0, '0);
    add_row(FUNC_COORD, T0 + 48'h700, 16'h0000, 1'b0, '0);
    add_row(FUNC_COORD, T0 + 48'h780, 16'h0400, 1'b0, '0);
    add_row(FUNC_PRODUCE, T0 + 48'h900, 16'h0, 1'b0, '0);
    add_row(FUNC_PRODUCE, T0 + 48'hB00, 16'h0, 1'b0, '0);
    add_row(FUNC_PRODUCE, T0 + 48'hD00, 16'h0, 1'b0, '0);
    add_row(FUNC_PRODUCE, T0 + 48'hF00, 16'h0, 1'b0, '0);
    add_row(FUNC_PRODUCE, T0 + 48'h1100, 16'h0, 1'b0, '0);
    add_row(FUNC_PRODUCE, T0 + 48'h900, 16'h0, 1'b0, '0);
    add_row(FUNC_COORD, T0 + 48'h1100 + 48'd3000, 16'h1234, 1'b0, '0);
    add_row(FUNC_PRODUCE, 48'h7FFF_FFFF_FFFF, 16'h0, 1'b0, '0);
    add_row(FUNC_COORD, 48'h8000_0000_0063, 16'hFFFF, 1'b0, '0);
    add_row(FUNC_COORD, 48'h8000_0000_0200, 16'h8000, 1'b0, '0);
    add_row(FUNC_PRODUCE, 48'h8000_0000_0400, 16'h0, 1'b0, '0);
    foreach (dir_rows[i])
      send_word(dir_rows[i].fn, dir_rows[i].now, dir_rows[i].ctv, dir_rows[i].typed,
                dir_rows[i].want);
    time_cursor = 48'h8000_0000_0400;
    drain();

    write_settings(16'($urandom), 16'($urandom), 16'd3, 24'd16000, 32'd5000);
    run_phase(200);
    drain();

    send_idle_pct = 73;
    recv_idle_pct = 35;
    write_settings(16'hFFFF, 16'h0000, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
    run_phase(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(16'($urandom), 16'($urandom), 16'($urandom), 24'd100, 32'd0);
    run_phase(70);
    // Stall the result side while words keep coming, so the input backs up.
    hold_off_req = 1'b1;
    run_phase(60);
    drain();
    run_phase(70);
    drain();

    if (expected_frames.size() != 0) fail_count++;
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
